### rtl/core/lcdseq_pkg.sv
package lcdseq_pkg;

    localparam logic [7:0] FUNC_SET_8BIT_WAKE = 8'b0011_0000;
    localparam logic [7:0] FUNC_SET_4BIT_BUS  = 8'b0010_0000;
    localparam logic [7:0] FUNC_SET_8BIT_2L   = 8'b0011_1000;
    localparam logic [7:0] FUNC_SET_4BIT_2L   = 8'b0010_1000;
    localparam logic [7:0] DISPLAY_OFF        = 8'b0000_1000;
    localparam logic [7:0] DISPLAY_CLEAR      = 8'b0000_0001;
    localparam logic [7:0] ENTRY_MODE_INC     = 8'b0000_0110;
    localparam logic [7:0] DISPLAY_ON         = 8'b0000_1100;
    localparam logic [7:0] SET_DDRAM_ADDR     = 8'b1000_0000;
    localparam logic [7:0] LINE1_BASE         = 8'd64;

    localparam logic [1:0] CMD_INIT    = 2'd0;
    localparam logic [1:0] CMD_SET_POS = 2'd1;
    localparam logic [1:0] CMD_WRITE   = 2'd2;

    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    localparam logic [2:0] REG_BUS_MODE = 3'd0;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] INIT_LAST_8BIT = 4'd7;
    localparam logic [STEP_W-1:0] INIT_LAST_4BIT = 4'd8;
    localparam logic [STEP_W-1:0] INIT_BUS_STEP  = 4'd3;
    localparam logic [STEP_W-1:0] INIT_SPLIT_STEP = 4'd4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] data;
    } lcdseq_entry_t;

    typedef struct packed {
        logic          valid;
        lcdseq_entry_t entry;
    } lcdseq_head_t;

    function automatic logic [7:0] init_byte(input logic [STEP_W-1:0] step,
                                             input logic four_bit);
        logic [7:0] b;
        b = DISPLAY_ON;
        if (four_bit)
        begin
            case (step)
                4'd0, 4'd1, 4'd2: b = FUNC_SET_8BIT_WAKE;
                4'd3:             b = FUNC_SET_4BIT_BUS;
                4'd4:             b = FUNC_SET_4BIT_2L;
                4'd5:             b = DISPLAY_OFF;
                4'd6:             b = DISPLAY_CLEAR;
                4'd7:             b = ENTRY_MODE_INC;
                default:          b = DISPLAY_ON;
            endcase
        end
        else
        begin
            case (step)
                4'd0, 4'd1, 4'd2: b = FUNC_SET_8BIT_WAKE;
                4'd3:             b = FUNC_SET_8BIT_2L;
                4'd4:             b = DISPLAY_OFF;
                4'd5:             b = DISPLAY_CLEAR;
                4'd6:             b = ENTRY_MODE_INC;
                default:          b = DISPLAY_ON;
            endcase
        end
        return b;
    endfunction

endpackage

### rtl/core/char_lcd_bus_sequencer_top.sv
// character lcd bus sequencer
// slave stream: one command per beat, tuser = command (0 init, 1 set position,
// 2 write data), tdata = column, row and character code
// master stream: one enable strobe per beat, tdata = data pins, tuser = register
// select, tlast on the final strobe of a command
// apb register 0 (bus_mode): 0 eight-bit bus, 1 four-bit bus with nibble split
// a beat is stored in the command queue, then its first strobe in the output register
// throughput: one strobe per cycle while the master side accepts; a character or
// position takes one strobe on an eight-bit bus and two on a four-bit bus after init,
// init takes 8 or 14 strobes, issued by the strobe sequencer from a two-entry queue
// unused commands and rows above 3 are taken and give no strobe
// a stalled master side holds its strobe; the command queue keeps taking beats
// until it is full
// reset clears the queue, the output valid flag, the nibble ready flag and bus_mode
module char_lcd_bus_sequencer_top #(
    parameter int LINE_COLUMNS = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // column[4:0], row[7:5], data_byte[15:8]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // bus_value[7:0]
    output logic        m_tuser,   // register_select[0]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lcdseq_pkg::*;

    logic          bus_mode_reg, bus_mode_next;
    logic          front_push;
    lcdseq_entry_t front_entry;
    logic          q_full;
    logic          q_pop;
    lcdseq_head_t  q_head;

    assign pready   = 1'b1;
    assign s_tready = !q_full;
    assign prdata   = (paddr == REG_BUS_MODE) ? {31'b0, bus_mode_reg} : 32'b0;

    always_comb
    begin
        bus_mode_next = bus_mode_reg;
        if (psel && penable && pwrite && paddr == REG_BUS_MODE)
        begin
            bus_mode_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_mode_reg <= 1'b0;
        end
        else
        begin
            bus_mode_reg <= bus_mode_next;
        end
    end

    lcdseq_front #(
        .LINE_COLUMNS (LINE_COLUMNS)
    ) u_front (
        .in_valid  (s_tvalid && s_tready),
        .command   (s_tuser),
        .column    (s_tdata[4:0]),
        .row       (s_tdata[7:5]),
        .data_byte (s_tdata[15:8]),
        .push      (front_push),
        .entry     (front_entry)
    );

    lcdseq_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_push),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head)
    );

    lcdseq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .bus_mode  (bus_mode_reg),
        .head      (q_head),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rs    (m_tuser),
        .out_value (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

### rtl/core/lcdseq_front.sv
module lcdseq_front #(
    parameter int LINE_COLUMNS = 20
) (
    input  logic                   in_valid,
    input  logic [1:0]             command,
    input  logic [4:0]             column,
    input  logic [2:0]             row,
    input  logic [7:0]             data_byte,
    output logic                   push,
    output lcdseq_pkg::lcdseq_entry_t entry
);
    import lcdseq_pkg::*;

    localparam logic [7:0] COL_MAX   = 8'(LINE_COLUMNS - 1);
    localparam logic [7:0] LINE2_BASE = 8'(LINE_COLUMNS);

    logic [7:0] col_ext;
    logic [7:0] col_sat;
    logic [7:0] base;
    logic [7:0] addr_sum;

    always_comb
    begin
        col_ext  = {3'b000, column};
        col_sat  = (col_ext > COL_MAX) ? COL_MAX : col_ext;
        base     = (row[0] ? LINE1_BASE : 8'd0) + (row[1] ? LINE2_BASE : 8'd0);
        addr_sum = base + col_sat;
        push          = 1'b0;
        entry.is_init = 1'b0;
        entry.rs      = RS_INSTR;
        entry.data    = data_byte;
        case (command)
            CMD_INIT:
            begin
                push          = in_valid;
                entry.is_init = 1'b1;
            end
            CMD_SET_POS:
            begin
                push       = in_valid && !row[2];
                entry.data = SET_DDRAM_ADDR | {1'b0, addr_sum[6:0]};
            end
            CMD_WRITE:
            begin
                push     = in_valid;
                entry.rs = RS_DATA;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/lcdseq_fifo.sv
module lcdseq_fifo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  lcdseq_pkg::lcdseq_entry_t push_entry,
    output logic                      full,
    input  logic                      pop,
    output lcdseq_pkg::lcdseq_head_t  head
);
    import lcdseq_pkg::*;

    lcdseq_entry_t mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic do_push;
    logic do_pop;

    always_comb
    begin
        full        = (count_reg == QCNT_W'(QUEUE_DEPTH));
        head.valid  = (count_reg != '0);
        head.entry  = mem[rd_ptr_reg];
        do_push     = push && !full;
        do_pop      = pop && head.valid;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/core/lcdseq_back.sv
module lcdseq_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     bus_mode,
    input  lcdseq_pkg::lcdseq_head_t head,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     out_rs,
    output logic [7:0]               out_value,
    output logic                     out_last
);
    import lcdseq_pkg::*;

    logic                 active_reg, active_next;
    lcdseq_entry_t        act_reg, act_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 phase_reg, phase_next;
    logic                 ready_reg, ready_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_rs_reg, out_rs_next;
    logic [7:0]           out_value_reg, out_value_next;
    logic                 out_last_reg, out_last_next;

    lcdseq_entry_t        cur;
    logic                 cur_valid;
    logic [STEP_W-1:0]    cur_step;
    logic                 cur_phase;
    logic [7:0]           cur_byte;
    logic                 split_ok;
    logic                 done_byte;
    logic                 item_done;
    logic                 out_free;
    logic                 emit;
    logic [7:0]           strobe_val;
    logic [STEP_W-1:0]    last_step;

    always_comb
    begin
        out_free  = !out_valid_reg || out_ready;
        cur_valid = active_reg || head.valid;
        cur       = active_reg ? act_reg : head.entry;
        cur_step  = active_reg ? step_reg : '0;
        cur_phase = active_reg ? phase_reg : 1'b0;
        emit      = cur_valid && out_free;
        pop       = emit && !active_reg;
        cur_byte  = cur.is_init ? init_byte(cur_step, bus_mode) : cur.data;
        split_ok  = cur.is_init ? (bus_mode && cur_step >= INIT_SPLIT_STEP) : ready_reg;
        last_step = bus_mode ? INIT_LAST_4BIT : INIT_LAST_8BIT;
        if (!bus_mode)
        begin
            strobe_val = cur_byte;
            done_byte  = 1'b1;
        end
        else if (!cur_phase)
        begin
            strobe_val = {cur_byte[7:4], 4'b0000};
            done_byte  = !split_ok;
        end
        else
        begin
            strobe_val = {cur_byte[3:0], 4'b0000};
            done_byte  = 1'b1;
        end
        item_done = done_byte && (!cur.is_init || cur_step == last_step);

        active_next    = active_reg;
        act_next       = act_reg;
        step_next      = step_reg;
        phase_next     = phase_reg;
        ready_next     = ready_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_rs_next    = out_rs_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_rs_next    = cur.rs;
            out_value_next = strobe_val;
            out_last_next  = item_done;
            act_next       = cur;
            active_next    = !item_done;
            if (done_byte)
            begin
                step_next  = cur_step + 1'b1;
                phase_next = 1'b0;
            end
            else
            begin
                step_next  = cur_step;
                phase_next = 1'b1;
            end
            if (cur.is_init)
            begin
                ready_next = bus_mode && (cur_step >= INIT_BUS_STEP);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        step_reg      <= step_next;
        out_rs_reg    <= out_rs_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            phase_reg     <= 1'b0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            phase_reg     <= phase_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rs    = out_rs_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTHESIS
    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("queue popped while empty");

    a_phase_in_item: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> active_reg)
        else $error("low nibble pending without an active item");

    a_wide_bus_whole_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !bus_mode) |-> done_byte)
        else $error("byte split on an eight-bit bus");

    a_init_clears_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && cur.is_init && cur_step == '0) |=> !ready_reg)
        else $error("nibble ready not cleared at start of init");

    a_stall_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_last_reg)))
        else $error("pending strobe changed while stalled");
`endif

endmodule
